>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files that check their own logic.
// Each macro expands to one labeled concurrent assertion on i_clk,
// muted while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/eprsf_pkg.sv
// ----------------------------------------------------------------------------
// eprsf_pkg
// Shared constants and controller/datapath link types for the encoder
// period to rpm block.
// ----------------------------------------------------------------------------
`default_nettype none

package eprsf_pkg;

    localparam int CAPTURE_BITS = 32;
    localparam int FRAC_BITS    = 8;
    localparam int CPR_W        = 16;
    localparam int RPM_OUT_W    = 16;
    localparam int STAMP_IN_W   = 32;

    localparam logic [CPR_W-1:0] CPR_RESET = 16'd20;

    // dividend: microseconds per minute in fixed point
    localparam logic [63:0] NUM_FX_64 = 64'd60000000 << FRAC_BITS;
    localparam int NUM_W = $clog2(NUM_FX_64 + 64'd1);
    localparam logic [NUM_W-1:0] NUM_FX = NUM_W'(NUM_FX_64);
    localparam int CNT_W = $clog2(NUM_W);

    // divisor: period times counts per rev
    localparam int DEN_W = CAPTURE_BITS + CPR_W;

    localparam logic [63:0] RPM_MAX_64 = 64'd200 << FRAC_BITS;
    localparam int RPM_W = $clog2(RPM_MAX_64 + 64'd1);
    localparam logic [RPM_W-1:0] RPM_MAX_FX     = RPM_W'(RPM_MAX_64);
    localparam logic [RPM_W-1:0] RPM_CONFIRM_FX = RPM_W'(64'd190 << FRAC_BITS);

    typedef struct packed {
        logic load_in;    // latch accepted beat
        logic load_mul;   // register period * cpr, arm divider
        logic div_step;   // one restoring divide step
        logic commit;     // update filter state and output register
    } t_dp_cmd;

    typedef struct packed {
        logic use_div;    // capture with a valid previous stamp
        logic div_last;   // current step is the final quotient bit
        logic out_free;   // output register can take a new beat
        logic is_timeout; // item in flight is a timeout
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/encoder_period_rpm_spike_filter.sv
// ----------------------------------------------------------------------------
// encoder_period_rpm_spike_filter
// Encoder edge timestamps to filtered wheel rpm (8.8 fixed point), one wheel.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_action, i_capture_time
//  output    out        o_valid / i_stall    o_speed_rpm, o_prev_speed_rpm,
//                                            o_in_transient
//  config    in         i_cfg_wr_en          i_cfg_wr_data (counts_per_rev)
//
// A capture with a nonzero previous stamp is latched on accept, then the
// period * counts product is registered, the bit-serial restoring divide
// runs (one quotient bit per cycle) and the result is committed.
// Timeouts and first captures skip the product and the divider.
// Synchronous active-low reset; counts_per_rev resets to 20, filter to zero.
// The output register holds one beat: a new beat is accepted while it waits,
// and that beat's commit waits for the output to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module encoder_period_rpm_spike_filter
    import eprsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input beats
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic [STAMP_IN_W-1:0] i_capture_time,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CPR_W-1:0]      i_cfg_wr_data,
    // result beats
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [RPM_OUT_W-1:0]       o_speed_rpm,
    output logic [RPM_OUT_W-1:0]       o_prev_speed_rpm,
    output logic                       o_in_transient
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns the input handshake
    eprsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: divider, filter state, output register
    eprsf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_capture_time   (i_capture_time),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_speed_rpm      (o_speed_rpm),
        .o_prev_speed_rpm (o_prev_speed_rpm),
        .o_in_transient   (o_in_transient)
    );

    // an accepted beat blocks the next one until its commit
    `ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, o_stall, "accept did not start work")

    // commit only happens while a beat is in flight
    `ASSERT_SAME(a_commit_busy, cmd.commit, o_stall, "commit with no beat in flight")

    // a timeout beat reports zero speed and zero previous speed
    `ASSERT_NEXT(a_timeout_zero, cmd.commit && sts.is_timeout,
        o_valid && o_speed_rpm == '0 && o_prev_speed_rpm == '0, "timeout result not zero")

    // divider never steps in the same cycle as it is armed
    `ASSERT_ALWAYS(a_div_arm, !(cmd.load_mul && cmd.div_step), "divider armed while stepping")

endmodule

`default_nettype wire

>>> rtl/eprsf_ctrl.sv
// ----------------------------------------------------------------------------
// eprsf_ctrl
// Sequencer: accept, multiply, bit-serial divide, filter commit.
// ----------------------------------------------------------------------------
`default_nettype none

module eprsf_ctrl
    import eprsf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FILT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_sts.use_div) begin
                    o_cmd.load_mul = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_FILT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                // hold until the output register has room
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eprsf_dp.sv
// ----------------------------------------------------------------------------
// eprsf_dp
// Period, product, restoring divider, spike filter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eprsf_dp
    import eprsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_action,
    input  wire logic [STAMP_IN_W-1:0] i_capture_time,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CPR_W-1:0]      i_cfg_wr_data,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic [RPM_OUT_W-1:0]       o_speed_rpm,
    output logic [RPM_OUT_W-1:0]       o_prev_speed_rpm,
    output logic                       o_in_transient
);

    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // control / architectural state
    logic [CPR_W-1:0]        r_cpr;
    logic [CAPTURE_BITS-1:0] r_last;
    logic [RPM_W-1:0]        r_held;
    logic [RPM_W-1:0]        r_filt;
    logic [RPM_W-1:0]        r_prev;
    logic                    r_trans;
    logic                    r_out_valid;

    // payload
    logic                    r_action;
    logic                    r_use_div;
    logic [CAPTURE_BITS-1:0] r_stamp;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic [RPM_OUT_W-1:0]    r_out_speed;
    logic [RPM_OUT_W-1:0]    r_out_prev;
    logic                    r_out_trans;

    logic [CAPTURE_BITS-1:0] period;
    logic [DEN_W-1:0]        n_den;
    logic [DEN_W:0]          rem_sh;
    logic [DEN_W:0]          sub;
    logic [RPM_W-1:0]        q_clamp;
    logic [RPM_W-1:0]        meas;
    logic [RPM_W+2:0]        meas5;
    logic [RPM_W+2:0]        filt6;
    logic [RPM_W-1:0]        n_filt;
    logic [RPM_W-1:0]        n_prev;
    logic [RPM_W-1:0]        n_held;
    logic                    n_trans;

    // period wraps modulo the capture width
    assign period = r_stamp - r_last;
    assign n_den  = period * r_cpr;

    // restoring divide, one quotient bit per step, MSB first
    assign rem_sh = {r_rem, NUM_FX[r_cnt]};
    assign sub    = rem_sh - {1'b0, r_den};

    // zero divisor yields an all-ones quotient, which clamps to max
    assign q_clamp = (r_quo > NUM_W'(RPM_MAX_FX)) ? RPM_MAX_FX : r_quo[RPM_W-1:0];
    assign meas    = r_use_div ? q_clamp : r_held;

    // normal-mode accept: 5*(m-r) < r  <=>  5m < 6r
    assign meas5 = ({3'b000, meas} << 2) + {3'b000, meas};
    assign filt6 = ({3'b000, r_filt} << 2) + ({3'b000, r_filt} << 1);

    always_comb begin
        n_filt  = r_filt;
        n_prev  = r_prev;
        n_held  = r_held;
        n_trans = r_trans;
        if (r_action == ACT_TIMEOUT) begin
            n_filt = '0;
            n_prev = '0;
        end else begin
            n_prev = r_filt;
            n_held = meas;
            if (!r_trans) begin
                if (meas5 < filt6) begin
                    n_filt = meas;
                end else begin
                    n_trans = 1'b1;
                end
            end else if (meas < RPM_CONFIRM_FX) begin
                n_filt  = meas;
                n_trans = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr       <= CPR_RESET;
            r_last      <= '0;
            r_held      <= '0;
            r_filt      <= '0;
            r_prev      <= '0;
            r_trans     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cpr <= i_cfg_wr_data;
            end
            if (i_cmd.commit) begin
                r_filt  <= n_filt;
                r_prev  <= n_prev;
                r_held  <= n_held;
                r_trans <= n_trans;
                if (r_action == ACT_CAPTURE) begin
                    r_last <= r_stamp;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action  <= i_action;
            r_stamp   <= i_capture_time[CAPTURE_BITS-1:0];
            r_use_div <= (i_action == ACT_CAPTURE) && (r_last != '0);
        end
        if (i_cmd.load_mul) begin
            r_den <= n_den;
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem <= sub[DEN_W] ? rem_sh[DEN_W-1:0] : sub[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ~sub[DEN_W]};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.commit) begin
            r_out_speed <= RPM_OUT_W'(n_filt);
            r_out_prev  <= RPM_OUT_W'(n_prev);
            r_out_trans <= n_trans;
        end
    end

    assign o_sts.use_div    = r_use_div;
    assign o_sts.div_last   = (r_cnt == '0);
    assign o_sts.out_free   = !r_out_valid || !i_stall;
    assign o_sts.is_timeout = (r_action == ACT_TIMEOUT);

    assign o_valid          = r_out_valid;
    assign o_speed_rpm      = r_out_speed;
    assign o_prev_speed_rpm = r_out_prev;
    assign o_in_transient   = r_out_trans;

endmodule

`default_nettype wire

>>> sim/tb_encoder_period_rpm_spike_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_period_rpm_spike_filter
// Self-checking bench for the encoder period to rpm block with spike filter.
// A queue-fed driver sends capture and timeout beats. A scoreboard model
// predicts each result beat when its input beat is accepted, and a monitor
// checks every result beat field by field. Both sides idle and stall at
// random. counts_per_rev is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_encoder_period_rpm_spike_filter;
    import eprsf_pkg::*;

    // 60e6 us per minute in fixed point, clamp and confirm thresholds
    localparam logic [63:0] SPEED_NUM     = 64'd60000000 << FRAC_BITS;
    localparam longint      SPEED_CAP     = longint'(200) << FRAC_BITS;
    localparam longint      SPEED_CONFIRM = longint'(190) << FRAC_BITS;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 60;    // longer than the divide path
    localparam int PHASE_ITEMS  = 158;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

    typedef enum logic {
        ACT_CAPTURE = 1'b0,
        ACT_TIMEOUT = 1'b1
    } t_enc_action;

    typedef struct packed {
        t_enc_action             action;
        logic [STAMP_IN_W-1:0]   stamp;
    } t_enc_beat;

    typedef struct packed {
        logic [RPM_OUT_W-1:0] speed;
        logic [RPM_OUT_W-1:0] prev_speed;
        logic                 transient;
    } t_speed_result;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT wiring. Every DUT input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  beat_valid     = 1'b0;
    logic                  beat_stall;
    logic                  beat_action    = ACT_CAPTURE;
    logic [STAMP_IN_W-1:0] beat_stamp     = '0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CPR_W-1:0]      cfg_wr_data    = '0;
    logic                  res_valid;
    logic                  res_stall      = 1'b0;
    logic [RPM_OUT_W-1:0]  res_speed;
    logic [RPM_OUT_W-1:0]  res_prev_speed;
    logic                  res_transient;

    always #1 i_clk = ~i_clk;

    encoder_period_rpm_spike_filter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (beat_valid),
        .o_stall          (beat_stall),
        .i_action         (beat_action),
        .i_capture_time   (beat_stamp),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_speed_rpm      (res_speed),
        .o_prev_speed_rpm (res_prev_speed),
        .o_in_transient   (res_transient)
    );

    // ------------------------------------------------------------------------
    // Speed model state: a private copy of the register and filter state.
    // Updated only when an input beat is accepted, or on a register write.
    // ------------------------------------------------------------------------
    logic [CPR_W-1:0]      model_cpr      = CPR_RESET;
    logic [STAMP_IN_W-1:0] model_last     = '0;
    longint                model_held     = 0;
    longint                model_filtered = 0;
    longint                model_previous = 0;
    logic                  model_trans    = 1'b0;

    t_enc_beat     pending_q[$];       // beats waiting for the driver
    t_speed_result speed_expect_q[$];  // predicted result beats, oldest first

    int errors       = 0;
    int results_seen = 0;

    // floor(60e6 * 2^FRAC / (period * cpr)), clamped; zero divisor saturates
    function automatic longint period_to_rpm(logic [STAMP_IN_W-1:0] period);
        logic [63:0] den;
        logic [63:0] quo;
        den = {32'd0, period} * {48'd0, model_cpr};
        if (den == 64'd0)
            return SPEED_CAP;
        quo = SPEED_NUM / den;
        return (quo > SPEED_CAP) ? SPEED_CAP : longint'(quo);
    endfunction

    function automatic t_speed_result predict_speed(t_enc_beat b);
        t_speed_result r;
        longint        meas;
        if (b.action == ACT_TIMEOUT) begin
            // timeout clears speed and previous speed, keeps the rest
            model_filtered = 0;
            model_previous = 0;
        end else begin
            model_previous = model_filtered;
            // a zero previous stamp means no period: reuse held measurement
            if (model_last != '0)
                model_held = period_to_rpm(b.stamp - model_last);
            model_last = b.stamp;
            meas = model_held;
            if (!model_trans) begin
                // reject rises of 20% or more; with speed 0 everything is a rise
                if (5 * (meas - model_filtered) < model_filtered)
                    model_filtered = meas;
                else
                    model_trans = 1'b1;
            end else if (meas < SPEED_CONFIRM) begin
                model_filtered = meas;
                model_trans    = 1'b0;
            end
        end
        r.speed      = model_filtered[RPM_OUT_W-1:0];
        r.prev_speed = model_previous[RPM_OUT_W-1:0];
        r.transient  = model_trans;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR result beat %0d: %s", results_seen, msg);
    endtask

    // idle stretch length: mostly short, a few long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 16);
        return $urandom_range(30, 100);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pops beats from pending_q, holds a beat until it is accepted,
    // predicts the result on acceptance, then maybe idles a while.
    // ------------------------------------------------------------------------
    t_enc_beat tx_beat;
    int        tx_gap   = 0;
    int        tx_burst = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_valid <= 1'b0;
            tx_gap   = 0;
            tx_burst = 0;
        end else begin
            if (beat_valid && !beat_stall) begin
                speed_expect_q.push_back(predict_speed(tx_beat));
                // occasional back-to-back stretch, otherwise random gaps
                if (tx_burst == 0 && $urandom_range(0, 49) == 0)
                    tx_burst = $urandom_range(20, 60);
                if (tx_burst > 0)
                    tx_burst--;
                else if ($urandom_range(0, 99) >= 55)
                    tx_gap = idle_len();
            end
            // a stalled beat stays on the bus unchanged
            if (!beat_valid || !beat_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    beat_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    tx_beat = pending_q.pop_front();
                    beat_valid  <= 1'b1;
                    beat_action <= tx_beat.action;
                    beat_stamp  <= tx_beat.stamp;
                end else begin
                    beat_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result beat against the oldest
    // prediction and drives the result stall. Two long hold-offs fill the
    // block so that it has to stall its input.
    // ------------------------------------------------------------------------
    t_speed_result rx_want;
    int            rx_hold = 0;
    int            rx_wait = 0;
    int            rx_open = 0;
    int            rx_roll;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                results_seen++;
                if (speed_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat speed=%0d", res_speed));
                end else begin
                    rx_want = speed_expect_q.pop_front();
                    if (res_speed !== rx_want.speed)
                        report_mismatch($sformatf("speed_rpm got %0d want %0d",
                                                  res_speed, rx_want.speed));
                    if (res_prev_speed !== rx_want.prev_speed)
                        report_mismatch($sformatf("prev_speed_rpm got %0d want %0d",
                                                  res_prev_speed, rx_want.prev_speed));
                    if (res_transient !== rx_want.transient)
                        report_mismatch($sformatf("in_transient got %0b want %0b",
                                                  res_transient, rx_want.transient));
                end
                if (results_seen == 150 || results_seen == 640)
                    rx_hold = HOLD_CYCLES;
            end

            if (rx_hold > 0) begin
                rx_hold--;
                res_stall <= 1'b1;
            end else if (rx_open > 0) begin
                rx_open--;
                res_stall <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_stall <= 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 2) begin
                    rx_open = $urandom_range(40, 150);
                    res_stall <= 1'b0;
                end else if (rx_roll < 30) begin
                    rx_wait = idle_len() - 1;
                    res_stall <= 1'b1;
                end else begin
                    res_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run with no beat moving for too long is a hang.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (beat_valid && !beat_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. stim_stamp tracks the timer value of the last capture.
    // ------------------------------------------------------------------------
    logic [STAMP_IN_W-1:0] stim_stamp = '0;
    logic [STAMP_IN_W-1:0] stim_base  = 32'd30000;

    task automatic push_capture(logic [STAMP_IN_W-1:0] stamp);
        t_enc_beat b;
        stim_stamp = stamp;
        b.action   = ACT_CAPTURE;
        b.stamp    = stamp;
        pending_q.push_back(b);
    endtask

    task automatic push_period(logic [STAMP_IN_W-1:0] period);
        push_capture(stim_stamp + period);
    endtask

    // the stamp of a timeout is ignored, so it carries noise
    task automatic push_timeout();
        t_enc_beat b;
        b.action = ACT_TIMEOUT;
        b.stamp  = $urandom();
        pending_q.push_back(b);
    endtask

    // pick a new cruising speed and the period that gives it at this cpr
    task automatic retarget();
        logic [63:0] t;
        logic [63:0] p;
        t = $urandom_range(64, 51200);
        p = SPEED_NUM / (t * {48'd0, model_cpr});
        stim_base = (p == 64'd0) ? 32'd1 : p[STAMP_IN_W-1:0];
    endtask

    // mostly smooth capture trains with jitter; spikes, speed changes,
    // repeated stamps, stray stamps and timeouts mixed in
    task automatic fill_random_phase(int count);
        int roll;
        retarget();
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                push_timeout();
            else if (roll < 8)
                push_period('0);
            else if (roll < 10)
                push_capture($urandom());
            else if (roll < 11)
                push_capture('0);
            else if (roll < 16)
                push_period(stim_base / $urandom_range(2, 8));
            else if (roll < 21) begin
                retarget();
                push_period(stim_base);
            end else
                push_period(stim_base - stim_base / 8 + $urandom_range(0, stim_base / 4));
        end
    endtask

    // sender pause: wait until every beat is sent and every result is back
    task automatic wait_drained();
        while (pending_q.size() != 0 || beat_valid || speed_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_cpr(logic [CPR_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        model_cpr    = value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    logic [CPR_W-1:0] cpr_plan[6];

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset cpr of 20 (100 rpm at a 30000 us period).
        push_capture('0);               // zero stamp: no period, held 0, rejected
        push_capture(32'd100000);       // previous stamp zero: held 0 reused
        push_period(32'd30000);         // 100 rpm rejected while speed is 0
        push_period(32'd30000);         // confirmed below 190 rpm
        push_period(32'd30000);
        push_period(32'd25000);         // exactly +20%: rejected
        push_period(32'd30000);
        push_period(32'd25100);         // just under +20%: accepted
        push_period('0);                // same stamp twice: 200 rpm
        push_period(32'd10000);         // clamped at 200 rpm, still not confirmed
        push_capture(32'hFFFF_FFF0);    // huge period, 0 rpm
        push_capture(32'h0000_7520);    // timer wrap, 30000 us period
        push_timeout();
        push_period(32'd30000);
        push_period(32'd30000);
        push_timeout();
        push_timeout();
        push_period(32'd31000);
        push_period(32'd15789);         // one step above the 190 rpm threshold
        push_period(32'd15790);         // two LSBs below it: confirmed
        push_capture(32'hFFFF_FFFF);
        push_capture('0);               // period 1 across the wrap
        push_capture(32'd12345);        // previous stamp zero again
        push_timeout();

        fill_random_phase(PHASE_ITEMS);

        // cpr extremes, a few ordinary values, then back to the reset value
        cpr_plan[0] = 16'd1;
        cpr_plan[1] = 16'hFFFF;
        cpr_plan[2] = 16'd360;
        cpr_plan[3] = 16'($urandom_range(3, 65534));
        cpr_plan[4] = 16'd2;
        cpr_plan[5] = CPR_RESET;
        foreach (cpr_plan[k]) begin
            write_cpr(cpr_plan[k]);
            stim_stamp = $urandom();
            fill_random_phase(k == 5 ? PHASE_ITEMS / 2 : PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/eprsf_pkg.sv
rtl/eprsf_ctrl.sv
rtl/eprsf_dp.sv
rtl/encoder_period_rpm_spike_filter.sv
sim/tb_encoder_period_rpm_spike_filter.sv
